[rtl/lea_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lea_pkg: shared types, constants and round function
// Round constants, key schedule step and ARX round for the block cipher.
// ----------------------------------------------------------------------------
package lea_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int KW_COUNT    = 8;
  localparam int DATA_WORDS  = 4;

  localparam logic [7:0][31:0] GOLDEN = {
    32'hf1bbcdcb, 32'h53845412, 32'hb54cda58, 32'h1715609f,
    32'h78dde6e5, 32'hdaa66d2c, 32'h3c6ef373, 32'h9e3779b9
  };

  // left rotates applied after each key word update
  localparam logic [3:0][4:0] KW_ROT = {5'd11, 5'd6, 5'd3, 5'd1};

  typedef struct packed {
    logic [DATA_WORDS-1:0][31:0] x;
    logic [KW_COUNT-1:0][31:0]   kw;
  } stage_t;

  function automatic logic [31:0] rol32(input logic [31:0] v, input logic [4:0] n);
    logic [31:0] r;
    if (n == 5'd0) begin
      r = v;
    end else begin
      r = (v << n) | (v >> (6'd32 - {1'b0, n}));
    end
    return r;
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
    logic [31:0] r;
    if (n == 5'd0) begin
      r = v;
    end else begin
      r = (v >> n) | (v << (6'd32 - {1'b0, n}));
    end
    return r;
  endfunction

  // one round: key schedule step, then the ARX mix and word rotation
  function automatic stage_t lea_round(input stage_t s, input logic [4:0] rnd);
    stage_t           o;
    logic [31:0]      d;
    logic [2:0]       b;
    logic [2:0]       k;
    logic [5:0][31:0] rk;
    logic [31:0]      t0;
    logic [31:0]      t1;
    logic [31:0]      t2;
    o = s;
    b = rnd[2:0];
    d = rol32(GOLDEN[b], rnd);
    for (int i = 0; i < 4; i++) begin
      k = b + 3'(i);
      o.kw[k] = rol32(s.kw[k] + rol32(d, 5'(i)), KW_ROT[i]);
    end
    for (int i = 0; i < 6; i++) begin
      rk[i] = o.kw[b + 3'(i)];
    end
    t0 = rol32((s.x[0] ^ rk[0]) + (s.x[1] ^ rk[1]), 5'd9);
    t1 = ror32((s.x[1] ^ rk[2]) + (s.x[2] ^ rk[3]), 5'd5);
    t2 = ror32((s.x[2] ^ rk[4]) + (s.x[3] ^ rk[5]), 5'd3);
    o.x[3] = s.x[0];
    o.x[0] = t0;
    o.x[1] = t1;
    o.x[2] = t2;
    return o;
  endfunction

  // last round: only the data words are kept
  function automatic logic [DATA_WORDS-1:0][31:0] lea_last_round(input stage_t s,
                                                                input logic [4:0] rnd);
    stage_t o;
    o = lea_round(s, rnd);
    return o.x;
  endfunction

endpackage

[rtl/lea_style_block_encrypt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lea_style_block_encrypt: pipelined 128-bit block encryption, 256-bit key
// Throughput: one block per cycle while busy is low; one register stage per
// round, and the round's key words travel down the pipe beside the data.
// Reset clears the stage valid bits and the key registers; busy is high
// in reset and the first cycle after it. Results are never stalled.
// ----------------------------------------------------------------------------
module lea_style_block_encrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] plain_word_0,
  input  logic [31:0] plain_word_1,
  input  logic [31:0] plain_word_2,
  input  logic [31:0] plain_word_3,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wr_data,
  output logic        done,
  output logic [31:0] cipher_word_0,
  output logic [31:0] cipher_word_1,
  output logic [31:0] cipher_word_2,
  output logic [31:0] cipher_word_3
);

  logic [lea_pkg::KW_COUNT-1:0][31:0]   key_reg;
  lea_pkg::stage_t                      pipe [0:lea_pkg::ROUND_COUNT-1];
  logic [lea_pkg::ROUND_COUNT-1:0]      vld;
  logic [lea_pkg::DATA_WORDS-1:0][31:0] out_x;
  logic                                 accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg <= '0;
    end else if (cfg_wr_en) begin
      key_reg[cfg_addr] <= cfg_wr_data;
    end
  end

  // input capture: the word and a snapshot of the key
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
    pipe[0].x  <= {plain_word_3, plain_word_2, plain_word_1, plain_word_0};
    pipe[0].kw <= key_reg;
  end

  for (genvar r = 0; r < lea_pkg::ROUND_COUNT - 1; r++) begin : g_round
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[r+1] <= 1'b0;
      end else begin
        vld[r+1] <= vld[r];
      end
      pipe[r+1] <= lea_pkg::lea_round(pipe[r], 5'(r));
    end
  end

  // last round keeps only the data words
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[lea_pkg::ROUND_COUNT-1];
    end
    out_x <= lea_pkg::lea_last_round(pipe[lea_pkg::ROUND_COUNT-1],
                                     5'(lea_pkg::ROUND_COUNT - 1));
  end

  assign cipher_word_0 = out_x[0];
  assign cipher_word_1 = out_x[1];
  assign cipher_word_2 = out_x[2];
  assign cipher_word_3 = out_x[3];

  // every accepted word comes out of the last round with done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##(lea_pkg::ROUND_COUNT) done)
    else $error("accepted word did not complete on time");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[lea_pkg::ROUND_COUNT-1]))
    else $error("done without a word in the last round");

  a_not_busy: assert property (@(posedge clk)
    !rst |=> !busy)
    else $error("busy high outside reset");

endmodule

[bench/lea_style_block_encrypt_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lea_style_block_encrypt_tb: self-checking bench for the block encryptor
// Writes the eight key words, streams plaintext blocks with random gaps and
// checks each ciphertext against a local model of the 32-round schedule.
// ----------------------------------------------------------------------------
module lea_style_block_encrypt_tb;

  typedef logic [lea_pkg::DATA_WORDS-1:0][31:0] block_t;
  typedef logic [lea_pkg::KW_COUNT-1:0][31:0]   key_t;

  localparam logic [31:0] DELTA [0:7] = '{
    32'h9e3779b9, 32'h3c6ef373, 32'hdaa66d2c, 32'h78dde6e5,
    32'h1715609f, 32'hb54cda58, 32'h53845412, 32'hf1bbcdcb
  };
  localparam int SCHED_ROT [0:3] = '{1, 3, 6, 11};

  localparam int PIPE_DEPTH     = lea_pkg::ROUND_COUNT + 1;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_BLOCKS   = 240;

  // key shapes used by the random phases
  typedef enum int {
    KEY_RANDOM, KEY_ZERO, KEY_ONES, KEY_128, KEY_192, KEY_ONE_WORD
  } key_shape_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] plain_word_0;
  logic [31:0] plain_word_1;
  logic [31:0] plain_word_2;
  logic [31:0] plain_word_3;
  logic        cfg_wr_en;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wr_data;
  logic        done;
  logic [31:0] cipher_word_0;
  logic [31:0] cipher_word_1;
  logic [31:0] cipher_word_2;
  logic [31:0] cipher_word_3;

  key_t   key_regs;
  block_t pending_ciphers [$];
  int     error_count;

  lea_style_block_encrypt dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .plain_word_0  (plain_word_0),
    .plain_word_1  (plain_word_1),
    .plain_word_2  (plain_word_2),
    .plain_word_3  (plain_word_3),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wr_data   (cfg_wr_data),
    .done          (done),
    .cipher_word_0 (cipher_word_0),
    .cipher_word_1 (cipher_word_1),
    .cipher_word_2 (cipher_word_2),
    .cipher_word_3 (cipher_word_3)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    logic [63:0] wide;
    wide = {v, v} << (n & 31);
    return wide[63:32];
  endfunction

  // full 32-round encryption of one block under the given key
  function automatic block_t encrypt_block(input key_t key, input block_t pt);
    key_t        kw;
    block_t      x;
    logic [31:0] d;
    logic [31:0] rk [0:5];
    logic [31:0] t0;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [2:0]  idx;
    kw = key;
    x  = pt;
    for (int r = 0; r < lea_pkg::ROUND_COUNT; r++) begin
      d = rotl(DELTA[r & 7], r);
      for (int i = 0; i < 4; i++) begin
        idx = 3'(r + i);
        kw[idx] = rotl(kw[idx] + rotl(d, i), SCHED_ROT[i]);
      end
      for (int i = 0; i < 6; i++) begin
        idx = 3'(r + i);
        rk[i] = kw[idx];
      end
      t0 = rotl((x[0] ^ rk[0]) + (x[1] ^ rk[1]), 9);
      t1 = rotl((x[1] ^ rk[2]) + (x[2] ^ rk[3]), 32 - 5);
      t2 = rotl((x[2] ^ rk[4]) + (x[3] ^ rk[5]), 32 - 3);
      x[3] = x[0];
      x[0] = t0;
      x[1] = t1;
      x[2] = t2;
    end
    return x;
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: w = 32'h0;
      1: w = 32'hffffffff;
      2: w = 32'h1 << $urandom_range(0, 31);
      3: w = ~(32'h1 << $urandom_range(0, 31));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic block_t random_block();
    block_t b;
    for (int i = 0; i < lea_pkg::DATA_WORDS; i++) b[i] = random_word();
    return b;
  endfunction

  // check each result word against the oldest prediction
  always @(posedge clk) begin : result_check
    block_t got;
    block_t want;
    if (!rst && done) begin
      got = {cipher_word_3, cipher_word_2, cipher_word_1, cipher_word_0};
      if (pending_ciphers.size() == 0) begin
        $display("%0t ERROR: unexpected word, expected none actual %032h", $time, got);
        error_count++;
      end else begin
        want = pending_ciphers.pop_front();
        for (int i = 0; i < lea_pkg::DATA_WORDS; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t ERROR: cipher_word_%0d expected %08h actual %08h",
                     $time, i, want[i], got[i]);
            error_count++;
          end
        end
      end
    end
  end

  // called right after a rising edge; leaves start high on return
  task automatic send_block(input block_t pt);
    start        <= 1'b1;
    plain_word_0 <= pt[0];
    plain_word_1 <= pt[1];
    plain_word_2 <= pt[2];
    plain_word_3 <= pt[3];
    do @(posedge clk); while (busy);
    pending_ciphers.push_back(encrypt_block(key_regs, pt));
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      // junk on the data ports while start is low
      plain_word_0 <= $urandom;
      plain_word_1 <= $urandom;
      plain_word_2 <= $urandom;
      plain_word_3 <= $urandom;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_gap();
    int n;
    if ($urandom_range(0, 99) < 8) n = $urandom_range(8, 40);
    else if ($urandom_range(0, 1) == 0) n = 0;
    else n = $urandom_range(1, 3);
    idle_cycles(n);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_ciphers.size() != 0);
  endtask

  task automatic write_key_word(input int idx, input logic [31:0] value);
    start       <= 1'b0;
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= 3'(idx);
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    key_regs[idx] = value;
  endtask

  // back-to-back writes; the enable drops once after the last word
  task automatic load_key(input key_t key);
    start <= 1'b0;
    for (int i = 0; i < lea_pkg::KW_COUNT; i++) begin
      cfg_wr_en   <= 1'b1;
      cfg_addr    <= 3'(i);
      cfg_wr_data <= key[i];
      @(posedge clk);
      key_regs[i] = key[i];
    end
    cfg_wr_en <= 1'b0;
  endtask

  // reset key is all zero
  task automatic test_reset_key();
    send_block('0);
    send_block('1);
    send_block({32'h00000001, 32'h0, 32'h0, 32'h80000000});
    send_block({32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555});
    idle_cycles(3);
    send_block({32'h7fffffff, 32'h80000000, 32'hfffffffe, 32'h00000001});
    send_block({32'h0, 32'h0, 32'h00010000, 32'h0});
  endtask

  task automatic test_key_extremes();
    key_t k;
    drain_results();
    load_key('1);
    send_block('0);
    send_block('1);
    send_block({32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff});
    drain_results();
    // 128-bit key, upper half zero-padded
    for (int i = 0; i < lea_pkg::KW_COUNT; i++) k[i] = (i < 4) ? $urandom : 32'h0;
    load_key(k);
    send_block('0);
    send_block({32'hdeadbeef, 32'h01234567, 32'h89abcdef, 32'hcafef00d});
    send_block('1);
  endtask

  // a single key word write must change the following blocks
  task automatic test_key_change();
    block_t pt;
    pt = {32'h0f0f0f0f, 32'hf0f0f0f0, 32'h12345678, 32'h9abcdef0};
    drain_results();
    load_key('0);
    send_block(pt);
    drain_results();
    write_key_word(5, 32'h00000001);
    send_block(pt);
    drain_results();
    write_key_word(0, 32'h80000000);
    send_block(pt);
    send_block(pt);
  endtask

  task automatic test_random_stream();
    key_t       k;
    key_shape_t shape;
    bit         no_gaps;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      shape = key_shape_t'(p % 6);
      for (int i = 0; i < lea_pkg::KW_COUNT; i++) k[i] = $urandom;
      case (shape)
        KEY_ZERO: k = '0;
        KEY_ONES: k = '1;
        KEY_128:  for (int i = 4; i < lea_pkg::KW_COUNT; i++) k[i] = 32'h0;
        KEY_192:  for (int i = 6; i < lea_pkg::KW_COUNT; i++) k[i] = 32'h0;
        default: ;
      endcase
      if (shape == KEY_ONE_WORD)
        write_key_word($urandom_range(0, lea_pkg::KW_COUNT - 1), $urandom);
      else load_key(k);
      no_gaps = 1'b0;
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        // sender hold-off: let the pipe run dry mid-phase
        if (n == PHASE_BLOCKS / 2) drain_results();
        else if (!no_gaps) random_gap();
        send_block(random_block());
      end
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    start        = 1'b0;
    plain_word_0 = '0;
    plain_word_1 = '0;
    plain_word_2 = '0;
    plain_word_3 = '0;
    cfg_wr_en    = 1'b0;
    cfg_addr     = '0;
    cfg_wr_data  = '0;
    key_regs     = '0;
    error_count  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_key();
    test_key_extremes();
    test_key_change();
    test_random_stream();

    drain_results();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t ERROR: timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
rtl/lea_pkg.sv
rtl/lea_style_block_encrypt.sv
bench/lea_style_block_encrypt_tb.sv
